### rtl/sliding_truncated_mean_filter_core_macros.svh
// Assertion macros shared by the sliding truncated mean filter RTL.
`ifndef SLIDING_TRUNCATED_MEAN_FILTER_CORE_MACROS_SVH
`define SLIDING_TRUNCATED_MEAN_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define STF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stf assertion failed");
`define STF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stf assertion failed");
`else
`define STF_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define STF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/stf_pkg.sv
// Shared types and constants of the sliding truncated mean filter.
`timescale 1ns / 1ps
package stf_pkg;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NSIGMA_W  = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  // Wide enough for window positions of the largest supported window.
  localparam int unsigned PTR_W     = 7;

  localparam logic [STATUS_W-1:0] STS_AVERAGED      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_NEIGHBOURS = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NONE_IN_BAND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NSIGMA = 1'b1;

  localparam logic [DATA_W-1:0]   RADIUS_RESET = 32'd65536;
  localparam logic [NSIGMA_W-1:0] NSIGMA_RESET = 16'd256;

  typedef struct packed {
    logic [PTR_W-1:0] base;
    logic [PTR_W-1:0] held;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] span;
    logic             final_flag;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_EMIT, F_DROP} front_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_R0_RD, B_R0_WAIT, B_SC_RD, B_SC_CHK, B_SC_ACC,
    B_MJ_RD, B_MJ_WAIT, B_MI_RD, B_MI_CMP, B_MJ_CHK,
    B_SQR, B_VAR_WAIT, B_SQRT, B_BAND, B_KP_RD, B_KP_CMP,
    B_MEAN_DIV, B_MEAN_WAIT, B_OUT
  } back_state_t;
endpackage

### rtl/stf_if.sv
// Stream interfaces for points in and filtered results out.
`timescale 1ns / 1ps
interface stf_in_if;
  logic                       valid;
  logic                       ready;
  logic [stf_pkg::DATA_W-1:0] range_value;
  logic [stf_pkg::DATA_W-1:0] charge;
  logic                       last_point;
  modport source(output valid, range_value, charge, last_point, input ready);
  modport sink(input valid, range_value, charge, last_point, output ready);
endinterface

interface stf_out_if;
  logic                         valid;
  logic                         ready;
  logic [stf_pkg::DATA_W-1:0]   filtered_charge;
  logic [stf_pkg::STATUS_W-1:0] status;
  logic                         last_result;
  modport source(output valid, filtered_charge, status, last_result, input ready);
  modport sink(input valid, filtered_charge, status, last_result, output ready);
endinterface

### rtl/stf_fifo.sv
// Four-entry job queue between the front and the back of the filter.
`timescale 1ns / 1ps
module stf_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stf_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output stf_pkg::job_t pop_data,
  output logic          empty
);
  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  stf_pkg::job_t    mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

### rtl/stf_div.sv
// Restoring divider, one quotient bit per cycle, shared by variance and mean.
`timescale 1ns / 1ps
module stf_div #(
  parameter int unsigned NUM_W = 76,
  parameter int unsigned DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    rem_sh   = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end
endmodule

### rtl/stf_front.sv
// Front end: takes points into the window and queues one job per due result.
`timescale 1ns / 1ps
module stf_front #(
  parameter int unsigned MAX_NEIGHBOR = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  stf_in_if.sink                     in_item,
  input  logic [stf_pkg::DATA_W-1:0] radius,
  input  logic                       back_idle,
  output logic                       job_push,
  output stf_pkg::job_t              job_data,
  input  logic                       job_full,
  output logic                       wr_en,
  output logic [$clog2(2*MAX_NEIGHBOR+1)-1:0] wr_addr,
  output logic [stf_pkg::DATA_W-1:0] wr_range,
  output logic [stf_pkg::DATA_W-1:0] wr_charge
);
  localparam int unsigned DEPTH  = 2 * MAX_NEIGHBOR + 1;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SPAN_W = $clog2(MAX_NEIGHBOR + 1);
  localparam int unsigned DW     = stf_pkg::DATA_W;

  stf_pkg::front_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  nop_r, nop_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic              last_r, last_nxt;

  logic [DW+2:0]     radius_x6;
  logic [DW-14:0]    span_raw;
  logic [SPAN_W-1:0] span_in;
  logic              accept, win_full, due;
  logic [IDX_W-1:0]  eff_base;
  logic [CNT_W-1:0]  eff_held, eff_nop;

  function automatic logic [IDX_W-1:0] next_base(input logic [IDX_W-1:0] b);
    next_base = (b == IDX_W'(DEPTH - 1)) ? '0 : b + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(b) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    phys = s[IDX_W-1:0];
  endfunction

  // Neighbour span is floor(radius * 6) in whole points, capped.
  assign radius_x6 = {1'b0, radius, 2'b00} + {2'b00, radius, 1'b0};
  assign span_raw  = radius_x6[DW+2:16];
  assign span_in   = (span_raw > (DW-13)'(MAX_NEIGHBOR)) ? SPAN_W'(MAX_NEIGHBOR)
                                                         : span_raw[SPAN_W-1:0];

  assign in_item.ready = (state_r == stf_pkg::F_IDLE) && back_idle;
  assign accept        = in_item.valid && in_item.ready;

  assign win_full = (held_r == CNT_W'(DEPTH));
  assign eff_base = win_full ? next_base(base_r) : base_r;
  assign eff_held = win_full ? held_r - 1'b1 : held_r;
  assign eff_nop  = (win_full && nop_r != '0) ? nop_r - 1'b1 : nop_r;

  assign wr_en     = accept;
  assign wr_addr   = phys(eff_base, eff_held);
  assign wr_range  = in_item.range_value;
  assign wr_charge = in_item.charge;

  assign due = (nop_r < held_r) &&
               (last_r || ((held_r - 1'b1 - nop_r) >= CNT_W'(span_r)));

  assign job_data.base       = stf_pkg::PTR_W'(base_r);
  assign job_data.held       = stf_pkg::PTR_W'(held_r);
  assign job_data.pos        = stf_pkg::PTR_W'(nop_r);
  assign job_data.span       = stf_pkg::PTR_W'(span_r);
  assign job_data.final_flag = last_r && (nop_r == held_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    nop_nxt   = nop_r;
    base_nxt  = base_r;
    span_nxt  = span_r;
    last_nxt  = last_r;
    job_push  = 1'b0;
    case (state_r)
      stf_pkg::F_IDLE: begin
        if (accept) begin
          base_nxt  = eff_base;
          held_nxt  = eff_held + 1'b1;
          nop_nxt   = eff_nop;
          span_nxt  = span_in;
          last_nxt  = in_item.last_point;
          state_nxt = stf_pkg::F_EMIT;
        end
      end
      stf_pkg::F_EMIT: begin
        if (due) begin
          if (!job_full) begin
            job_push  = 1'b1;
            nop_nxt   = nop_r + 1'b1;
            state_nxt = stf_pkg::F_DROP;
          end
        end else begin
          if (last_r) begin
            held_nxt = '0;
            nop_nxt  = '0;
          end
          state_nxt = stf_pkg::F_IDLE;
        end
      end
      stf_pkg::F_DROP: begin
        // Points more than a span behind the next pending result are retired.
        if (nop_r > CNT_W'(span_r)) begin
          base_nxt = next_base(base_r);
          held_nxt = held_r - 1'b1;
          nop_nxt  = nop_r - 1'b1;
        end else begin
          state_nxt = stf_pkg::F_EMIT;
        end
      end
      default: state_nxt = stf_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stf_pkg::F_IDLE;
      held_r  <= '0;
      nop_r   <= '0;
      base_r  <= '0;
      span_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      nop_r   <= nop_nxt;
      base_r  <= base_nxt;
      span_r  <= span_nxt;
      last_r  <= last_nxt;
    end
  end
endmodule

### rtl/stf_back.sv
// Back end: holds the window and works out one truncated mean per job.
`timescale 1ns / 1ps
module stf_back #(
  parameter int unsigned MAX_NEIGHBOR = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stf_pkg::job_t                job_data,
  input  logic                         job_empty,
  output logic                         job_pop,
  output logic                         busy,
  input  logic                         wr_en,
  input  logic [$clog2(2*MAX_NEIGHBOR+1)-1:0] wr_addr,
  input  logic [stf_pkg::DATA_W-1:0]   wr_range,
  input  logic [stf_pkg::DATA_W-1:0]   wr_charge,
  input  logic [stf_pkg::DATA_W-1:0]   radius,
  input  logic [stf_pkg::NSIGMA_W-1:0] nsigma,
  stf_out_if.source                    out_item
);
  localparam int unsigned DEPTH = 2 * MAX_NEIGHBOR + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DW    = stf_pkg::DATA_W;
  localparam int unsigned NSW   = stf_pkg::NSIGMA_W;
  localparam int unsigned S1_W  = DW + CNT_W;
  localparam int unsigned S2_W  = 2 * DW + CNT_W;
  localparam int unsigned NUM_W = 2 * DW + 2 * CNT_W;
  localparam int unsigned DEN_W = 2 * CNT_W;
  localparam int unsigned BIT_W = $clog2(DW);

  logic [DW-1:0] mem_range [DEPTH];
  logic [DW-1:0] mem_charge [DEPTH];
  logic [DW-1:0] rd_range_r, rd_charge_r;
  logic          rd_en;
  logic [IDX_W-1:0] rd_addr;

  stf_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic              final_r, final_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [DEPTH-1:0]  mask_r, mask_nxt;
  logic [DW-1:0]     r0_r, r0_nxt, own_r, own_nxt, x_r, x_nxt;
  logic [2*DW-1:0]   sq_r, sq_nxt;
  logic              q_r, q_nxt;
  logic [S1_W-1:0]   s1_r, s1_nxt, sum_r, sum_nxt;
  logic [S2_W-1:0]   s2_r, s2_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, lt_r, lt_nxt, le_r, le_nxt, kept_r, kept_nxt;
  logic [DW-1:0]     xj_r, xj_nxt, med_r, med_nxt, rms_r, rms_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [S1_W-1:0]   mplier_r, mplier_nxt;
  logic [2*DW-1:0]   var_r, var_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [DW+NSW-1:0] band_r, band_nxt;
  logic [DW-1:0]     res_value_r, res_value_nxt;
  logic [stf_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     out_value_r, out_value_nxt;
  logic [stf_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;

  logic [CNT_W-1:0]  jb_pos, jb_span, jb_held;
  logic [CNT_W:0]    jb_top;
  logic [DW-1:0]     gap, t_bit;
  logic [CNT_W-1:0]  k;

  stf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(b) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    phys = s[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_range[wr_addr]  <= wr_range;
      mem_charge[wr_addr] <= wr_charge;
    end
    if (rd_en) begin
      rd_range_r  <= mem_range[rd_addr];
      rd_charge_r <= mem_charge[rd_addr];
    end
  end

  assign busy                     = (state_r != stf_pkg::B_IDLE);
  assign out_item.valid           = out_valid_r;
  assign out_item.filtered_charge = out_value_r;
  assign out_item.status          = out_status_r;
  assign out_item.last_result     = out_last_r;

  assign jb_pos  = job_data.pos[CNT_W-1:0];
  assign jb_span = job_data.span[CNT_W-1:0];
  assign jb_held = job_data.held[CNT_W-1:0];
  assign jb_top  = (CNT_W+1)'(jb_pos) + (CNT_W+1)'(jb_span);
  assign k       = cnt_r >> 1;
  assign t_bit   = rms_r | (DW'(1) << bit_r);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    final_nxt      = final_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    mask_nxt       = mask_r;
    r0_nxt         = r0_r;
    own_nxt        = own_r;
    x_nxt          = x_r;
    sq_nxt         = sq_r;
    q_nxt          = q_r;
    s1_nxt         = s1_r;
    s2_nxt         = s2_r;
    cnt_nxt        = cnt_r;
    lt_nxt         = lt_r;
    le_nxt         = le_r;
    xj_nxt         = xj_r;
    med_nxt        = med_r;
    acc_nxt        = acc_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    var_nxt        = var_r;
    rms_nxt        = rms_r;
    bit_nxt        = bit_r;
    band_nxt       = band_r;
    sum_nxt        = sum_r;
    kept_nxt       = kept_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = (out_valid_r && out_item.ready) ? 1'b0 : out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    job_pop        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    gap            = '0;
    case (state_r)
      stf_pkg::B_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          base_nxt  = job_data.base[IDX_W-1:0];
          pos_nxt   = jb_pos;
          final_nxt = job_data.final_flag;
          lo_nxt    = (jb_pos > jb_span) ? jb_pos - jb_span : '0;
          hi_nxt    = (jb_top > (CNT_W+1)'(jb_held - 1'b1)) ? jb_held - 1'b1
                                                            : jb_top[CNT_W-1:0];
          state_nxt = stf_pkg::B_R0_RD;
        end
      end
      stf_pkg::B_R0_RD: begin
        rd_en     = 1'b1;
        rd_addr   = phys(base_r, pos_r);
        state_nxt = stf_pkg::B_R0_WAIT;
      end
      stf_pkg::B_R0_WAIT: begin
        r0_nxt    = rd_range_r;
        own_nxt   = rd_charge_r;
        i_nxt     = lo_r;
        mask_nxt  = '0;
        s1_nxt    = '0;
        s2_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = stf_pkg::B_SC_RD;
      end
      stf_pkg::B_SC_RD: begin
        rd_en     = 1'b1;
        rd_addr   = phys(base_r, i_r);
        state_nxt = stf_pkg::B_SC_CHK;
      end
      stf_pkg::B_SC_CHK: begin
        gap       = (rd_range_r > r0_r) ? rd_range_r - r0_r : r0_r - rd_range_r;
        q_nxt     = (gap <= radius);
        x_nxt     = rd_charge_r;
        sq_nxt    = rd_charge_r * rd_charge_r;
        state_nxt = stf_pkg::B_SC_ACC;
      end
      stf_pkg::B_SC_ACC: begin
        if (q_r) begin
          s1_nxt   = s1_r + S1_W'(x_r);
          s2_nxt   = s2_r + S2_W'(sq_r);
          cnt_nxt  = cnt_r + 1'b1;
          mask_nxt[i_r[IDX_W-1:0]] = 1'b1;
        end
        if (i_r == hi_r) begin
          if (cnt_r == '0 && !q_r) begin
            res_value_nxt  = own_r;
            res_status_nxt = stf_pkg::STS_NO_NEIGHBOURS;
            state_nxt      = stf_pkg::B_OUT;
          end else begin
            j_nxt     = lo_r;
            state_nxt = stf_pkg::B_MJ_RD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = stf_pkg::B_SC_RD;
        end
      end
      // Upper median: the kept charge with fewer than k+1 smaller and more
      // than k not greater, found by ranking each candidate in turn.
      stf_pkg::B_MJ_RD: begin
        if (!mask_r[j_r[IDX_W-1:0]]) begin
          j_nxt = j_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(base_r, j_r);
          state_nxt = stf_pkg::B_MJ_WAIT;
        end
      end
      stf_pkg::B_MJ_WAIT: begin
        xj_nxt    = rd_charge_r;
        i_nxt     = lo_r;
        lt_nxt    = '0;
        le_nxt    = '0;
        state_nxt = stf_pkg::B_MI_RD;
      end
      stf_pkg::B_MI_RD: begin
        if (i_r > hi_r) begin
          state_nxt = stf_pkg::B_MJ_CHK;
        end else if (!mask_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(base_r, i_r);
          state_nxt = stf_pkg::B_MI_CMP;
        end
      end
      stf_pkg::B_MI_CMP: begin
        if (rd_charge_r < xj_r) begin
          lt_nxt = lt_r + 1'b1;
        end
        if (rd_charge_r <= xj_r) begin
          le_nxt = le_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = stf_pkg::B_MI_RD;
      end
      stf_pkg::B_MJ_CHK: begin
        if (lt_r <= k && k < le_r) begin
          med_nxt = xj_r;
          if (cnt_r == CNT_W'(1)) begin
            rms_nxt   = xj_r;
            state_nxt = stf_pkg::B_BAND;
          end else begin
            acc_nxt    = '0;
            mcand_nxt  = NUM_W'(s1_r);
            mplier_nxt = s1_r;
            state_nxt  = stf_pkg::B_SQR;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = stf_pkg::B_MJ_RD;
        end
      end
      // Square of the sum by shift and add, then the variance division.
      stf_pkg::B_SQR: begin
        if (mplier_r == '0) begin
          div_start = 1'b1;
          div_num   = NUM_W'(s2_r * cnt_r) - acc_r;
          div_den   = DEN_W'(cnt_r * (cnt_r - 1'b1));
          state_nxt = stf_pkg::B_VAR_WAIT;
        end else begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end
      end
      stf_pkg::B_VAR_WAIT: begin
        if (div_done) begin
          var_nxt   = div_quo[2*DW-1:0];
          rms_nxt   = '0;
          bit_nxt   = BIT_W'(DW - 1);
          state_nxt = stf_pkg::B_SQRT;
        end
      end
      stf_pkg::B_SQRT: begin
        if (t_bit * t_bit <= var_r) begin
          rms_nxt = t_bit;
        end
        if (bit_r == '0) begin
          state_nxt = stf_pkg::B_BAND;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      stf_pkg::B_BAND: begin
        band_nxt  = rms_r * nsigma;
        i_nxt     = lo_r;
        sum_nxt   = '0;
        kept_nxt  = '0;
        state_nxt = stf_pkg::B_KP_RD;
      end
      stf_pkg::B_KP_RD: begin
        if (i_r > hi_r) begin
          state_nxt = stf_pkg::B_MEAN_DIV;
        end else if (!mask_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(base_r, i_r);
          state_nxt = stf_pkg::B_KP_CMP;
        end
      end
      stf_pkg::B_KP_CMP: begin
        gap = (rd_charge_r > med_r) ? rd_charge_r - med_r : med_r - rd_charge_r;
        if ((DW+NSW)'({gap, 8'h00}) < band_r) begin
          sum_nxt  = sum_r + S1_W'(rd_charge_r);
          kept_nxt = kept_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = stf_pkg::B_KP_RD;
      end
      stf_pkg::B_MEAN_DIV: begin
        if (kept_r == '0) begin
          res_value_nxt  = own_r;
          res_status_nxt = stf_pkg::STS_NONE_IN_BAND;
          state_nxt      = stf_pkg::B_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(sum_r);
          div_den   = DEN_W'(kept_r);
          state_nxt = stf_pkg::B_MEAN_WAIT;
        end
      end
      stf_pkg::B_MEAN_WAIT: begin
        if (div_done) begin
          res_value_nxt  = div_quo[DW-1:0];
          res_status_nxt = stf_pkg::STS_AVERAGED;
          state_nxt      = stf_pkg::B_OUT;
        end
      end
      stf_pkg::B_OUT: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = final_r;
          state_nxt      = stf_pkg::B_IDLE;
        end
      end
      default: state_nxt = stf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    final_r      <= final_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    mask_r       <= mask_nxt;
    r0_r         <= r0_nxt;
    own_r        <= own_nxt;
    x_r          <= x_nxt;
    sq_r         <= sq_nxt;
    q_r          <= q_nxt;
    s1_r         <= s1_nxt;
    s2_r         <= s2_nxt;
    cnt_r        <= cnt_nxt;
    lt_r         <= lt_nxt;
    le_r         <= le_nxt;
    xj_r         <= xj_nxt;
    med_r        <= med_nxt;
    acc_r        <= acc_nxt;
    mcand_r      <= mcand_nxt;
    mplier_r     <= mplier_nxt;
    var_r        <= var_nxt;
    rms_r        <= rms_nxt;
    bit_r        <= bit_nxt;
    band_r       <= band_nxt;
    sum_r        <= sum_nxt;
    kept_r       <= kept_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end
endmodule

### rtl/sliding_truncated_mean_filter_core.sv
// Top level of the sliding truncated mean filter: config registers and wiring.
//
//   channel  direction  handshake              payload
//   in_item  in         valid/ready            range_value, charge, last_point
//   out_item out        valid/ready            filtered_charge, status, last_result
//   cfg_*    in         cfg_we, no back-press  cfg_index, cfg_data
//
// Run time per result is set by the median ranking pass and the serial divider.
// A point is taken only when the job queue and the back end are empty.
// Reset is synchronous; the window memory is not cleared and needs no pass.
// The output register lets the next job run while a result waits to be taken.
`timescale 1ns / 1ps
`include "sliding_truncated_mean_filter_core_macros.svh"
module sliding_truncated_mean_filter_core #(
  parameter int unsigned MAX_NEIGHBOR = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  stf_in_if.sink                        in_item,
  stf_out_if.source                     out_item,
  input  logic                          cfg_we,
  input  logic [stf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stf_pkg::DATA_W-1:0]    cfg_data
);
  localparam int unsigned IDX_W = $clog2(2 * MAX_NEIGHBOR + 1);

  logic [stf_pkg::DATA_W-1:0]   radius_r, radius_nxt;
  logic [stf_pkg::NSIGMA_W-1:0] nsigma_r, nsigma_nxt;

  stf_pkg::job_t job_in, job_out;
  logic job_push, job_pop, job_full, job_empty, back_busy, back_idle;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [stf_pkg::DATA_W-1:0] wr_range, wr_charge;

  always_comb begin
    radius_nxt = radius_r;
    nsigma_nxt = nsigma_r;
    if (cfg_we) begin
      if (cfg_index == stf_pkg::CFG_RADIUS) begin
        radius_nxt = cfg_data;
      end else if (cfg_index == stf_pkg::CFG_NSIGMA) begin
        nsigma_nxt = cfg_data[stf_pkg::NSIGMA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= stf_pkg::RADIUS_RESET;
      nsigma_r <= stf_pkg::NSIGMA_RESET;
    end else begin
      radius_r <= radius_nxt;
      nsigma_r <= nsigma_nxt;
    end
  end

  assign back_idle = job_empty && !back_busy;

  stf_front #(.MAX_NEIGHBOR(MAX_NEIGHBOR)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .radius    (radius_r),
    .back_idle (back_idle),
    .job_push  (job_push),
    .job_data  (job_in),
    .job_full  (job_full),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_range  (wr_range),
    .wr_charge (wr_charge)
  );

  stf_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  stf_back #(.MAX_NEIGHBOR(MAX_NEIGHBOR)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_data  (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_range  (wr_range),
    .wr_charge (wr_charge),
    .radius    (radius_r),
    .nsigma    (nsigma_r),
    .out_item  (out_item)
  );

  // A new point is never taken in the cycle after one was accepted.
  `STF_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_item.valid && in_item.ready, !in_item.ready)
  `STF_ASSERT_NOW(a_status_known, clk, rst_n, out_item.valid, out_item.status == stf_pkg::STS_AVERAGED || out_item.status == stf_pkg::STS_NO_NEIGHBOURS || out_item.status == stf_pkg::STS_NONE_IN_BAND)
  // Memory writes only happen while the back end is not reading the window.
  `STF_ASSERT_NOW(a_write_when_idle, clk, rst_n, wr_en, back_idle)
endmodule
